FILE: src/tspsi_pkg.sv
// Package with the item types and codes of the PSI section reassembler.
package tspsi_pkg;

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_FINAL = 2'd1,
		KIND_CLOSE = 2'd2,
		KIND_DROP  = 2'd3
	} kind_t;

	typedef enum logic [4:0] {
		PH_IDLE       = 5'b00001,
		PH_TAIL       = 5'b00010,
		PH_HEAD       = 5'b00100,
		PH_BODY_START = 5'b01000,
		PH_BODY_CONT  = 5'b10000
	} phase_t;

	localparam int unsigned MAX_RESULTS = 3;
	localparam logic [7:0] STUFF_BYTE = 8'hFF;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       packet_first;
		logic       packet_last;
		logic       unit_start;
		logic [3:0] continuity;
	} in_item_t;

	typedef struct packed {
		logic [7:0] section_byte;
		kind_t      kind;
		logic       run_last;
	} out_item_t;

endpackage

FILE: src/ts_psi_section_reassembler_unit.sv
// Top level of the PSI section reassembler: section state and result queue.
//
// The item channel (item_valid, item_ready, item) takes one transport payload
// byte per cycle while item_ready is high, with packet marks, unit start flag
// and continuity count. The result channel (result_valid, result_ready,
// result) returns the section bytes, close markers and drop markers, with
// run_last on the last result that belongs to one input item.
// All decoding for an item happens in the cycle it is accepted; its results
// sit in a three-entry result register and the first one is offered in the
// next cycle.
// An item that causes several results holds the result channel while they
// are handed over one by one through the single result port. A new item is
// taken while the last queued result is being handed over.
// If the receiver stalls, queued results hold and item_ready drops once the
// queue would not empty in that cycle.
// Reset clears the section state and empties the result queue; the continuity
// reference is unknown until the first packet arrives.
module ts_psi_section_reassembler_unit
	import tspsi_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_ready,
	output out_item_t result
);

	phase_t      phase_q;
	logic [3:0]  prev_cc_q;
	logic        cc_known_q;
	logic        collecting_q;
	logic [7:0]  ptr_rem_q;
	logic [15:0] hdr_hold_q;
	logic [1:0]  hdr_cnt_q;
	logic [11:0] sec_rem_q;

	out_item_t   buf_q [MAX_RESULTS];
	logic [1:0]  cnt_q;

	phase_t      ph;
	logic [3:0]  prev_cc;
	logic        cc_known;
	logic        collecting;
	logic [7:0]  ptr_rem;
	logic [15:0] hdr_hold;
	logic [1:0]  hdr_cnt;
	logic [11:0] sec_rem;
	out_item_t   res [MAX_RESULTS];
	logic [1:0]  n;

	logic        item_fire;
	logic        result_fire;

	assign result_valid = (cnt_q != 2'd0);
	assign result = buf_q[0];
	assign item_ready = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && result_ready);
	assign item_fire = item_valid && item_ready;
	assign result_fire = result_valid && result_ready;

	always_comb begin
		logic       use_byte;
		logic       disc;
		logic [7:0] b;
		logic [11:0] len;
		ph = phase_q;
		prev_cc = prev_cc_q;
		cc_known = cc_known_q;
		collecting = collecting_q;
		ptr_rem = ptr_rem_q;
		hdr_hold = hdr_hold_q;
		hdr_cnt = hdr_cnt_q;
		sec_rem = sec_rem_q;
		n = 2'd0;
		use_byte = 1'b1;
		disc = 1'b0;
		b = item.payload_byte;
		len = {hdr_hold_q[3:0], b};
		for (int i = 0; i < MAX_RESULTS; i++) begin
			res[i] = '{section_byte: 8'd0, kind: KIND_DATA, run_last: 1'b0};
		end

		if (item.packet_first) begin
			if ((ph == PH_TAIL) && collecting) begin
				res[n] = '{section_byte: 8'd0, kind: KIND_DROP, run_last: 1'b0};
				n = n + 2'd1;
				collecting = 1'b0;
			end
			ph = PH_IDLE;
			hdr_cnt = 2'd0;
			disc = cc_known && ((prev_cc + 4'd1) != item.continuity);
			prev_cc = item.continuity;
			cc_known = 1'b1;
			use_byte = 1'b0;
			if (disc) begin
				if (collecting) begin
					res[n] = '{section_byte: 8'd0, kind: KIND_DROP, run_last: 1'b0};
					n = n + 2'd1;
					collecting = 1'b0;
				end
			end else if (item.unit_start) begin
				if ((b == 8'd0) && !item.packet_last) begin
					if (collecting) begin
						res[n] = '{section_byte: 8'd0, kind: KIND_CLOSE, run_last: 1'b0};
						n = n + 2'd1;
						collecting = 1'b0;
					end
					ph = PH_HEAD;
				end else begin
					ptr_rem = b;
					ph = PH_TAIL;
				end
			end else if (collecting) begin
				ph = PH_BODY_CONT;
				use_byte = 1'b1;
			end
		end

		if (use_byte) begin
			unique case (ph) inside
				PH_TAIL: begin
					if (collecting) begin
						res[n] = '{section_byte: b, kind: KIND_DATA, run_last: 1'b0};
						n = n + 2'd1;
					end
					if (ptr_rem != 8'd0) begin
						ptr_rem = ptr_rem - 8'd1;
					end
					if ((ptr_rem == 8'd0) && !item.packet_last) begin
						if (collecting) begin
							res[n - 2'd1].kind = KIND_FINAL;
							collecting = 1'b0;
						end
						ph = PH_HEAD;
						hdr_cnt = 2'd0;
					end
				end
				PH_HEAD: begin
					if ((hdr_cnt == 2'd0) && (b == STUFF_BYTE)) begin
						ph = PH_IDLE;
					end else if (hdr_cnt < 2'd2) begin
						hdr_hold = {hdr_hold[7:0], b};
						hdr_cnt = hdr_cnt + 2'd1;
					end else begin
						res[0] = '{section_byte: hdr_hold[15:8], kind: KIND_DATA,
							run_last: 1'b0};
						res[1] = '{section_byte: hdr_hold[7:0], kind: KIND_DATA,
							run_last: 1'b0};
						res[2] = '{section_byte: b,
							kind: (len == 12'd0) ? KIND_FINAL : KIND_DATA, run_last: 1'b0};
						n = 2'd3;
						hdr_cnt = 2'd0;
						if (len != 12'd0) begin
							collecting = 1'b1;
							sec_rem = len;
							ph = PH_BODY_START;
						end
					end
				end
				PH_BODY_START, PH_BODY_CONT: begin
					if (sec_rem != 12'd0) begin
						sec_rem = sec_rem - 12'd1;
					end
					if (sec_rem == 12'd0) begin
						res[n] = '{section_byte: b, kind: KIND_FINAL, run_last: 1'b0};
						n = n + 2'd1;
						collecting = 1'b0;
						ph = (ph == PH_BODY_START) ? PH_HEAD : PH_IDLE;
						hdr_cnt = 2'd0;
					end else begin
						res[n] = '{section_byte: b, kind: KIND_DATA, run_last: 1'b0};
						n = n + 2'd1;
					end
				end
				default: begin
				end
			endcase
		end

		if (item.packet_last) begin
			if ((ph == PH_TAIL) && collecting) begin
				res[n] = '{section_byte: 8'd0, kind: KIND_DROP, run_last: 1'b0};
				n = n + 2'd1;
				collecting = 1'b0;
			end
			ph = PH_IDLE;
			hdr_cnt = 2'd0;
		end

		if (n != 2'd0) begin
			res[n - 2'd1].run_last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			prev_cc_q <= 4'd0;
			cc_known_q <= 1'b0;
			collecting_q <= 1'b0;
			ptr_rem_q <= 8'd0;
			hdr_hold_q <= 16'd0;
			hdr_cnt_q <= 2'd0;
			sec_rem_q <= 12'd0;
			cnt_q <= 2'd0;
		end else begin
			if (item_fire) begin
				phase_q <= ph;
				prev_cc_q <= prev_cc;
				cc_known_q <= cc_known;
				collecting_q <= collecting;
				ptr_rem_q <= ptr_rem;
				hdr_hold_q <= hdr_hold;
				hdr_cnt_q <= hdr_cnt;
				sec_rem_q <= sec_rem;
				cnt_q <= n;
			end else if (result_fire) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_fire) begin
			for (int i = 0; i < MAX_RESULTS; i++) begin
				buf_q[i] <= res[i];
			end
		end else if (result_fire) begin
			for (int i = 0; i < MAX_RESULTS - 1; i++) begin
				buf_q[i] <= buf_q[i + 1];
			end
		end
	end

endmodule

FILE: bench/testbench.sv
// Self-checking testbench that streams transport payload bytes into the PSI section reassembler.
`timescale 1ns / 100ps

module testbench
	import tspsi_pkg::*;
();

	typedef logic [7:0] byte_q_t[$];

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      item_valid = 1'b0;
	logic      item_ready;
	in_item_t  item = '0;
	logic      result_valid;
	logic      result_ready = 1'b0;
	out_item_t result;

	in_item_t  pending_bytes[$];
	out_item_t expected_results[$];
	int        mismatches = 0;
	int        send_hold = 0;
	int        recv_hold = 0;
	bit        send_quiet = 1'b0;
	bit        recv_quiet = 1'b0;

	phase_t      sec_phase = PH_IDLE;
	logic [3:0]  last_cc = '0;
	bit          cc_known = 1'b0;
	bit          collecting = 1'b0;
	logic [7:0]  ptr_left = '0;
	logic [15:0] hdr_hold = '0;
	logic [1:0]  hdr_cnt = '0;
	logic [12:0] body_left = '0;

	ts_psi_section_reassembler_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always #5 clk = ~clk;

	function automatic int draw_gap(inout bit quiet);
		if ($urandom_range(0, 24) == 0) begin
			quiet = ~quiet;
		end
		return quiet ? 0 : $urandom_range(0, 14);
	endfunction

	function automatic out_item_t make_res(logic [7:0] b, kind_t k);
		out_item_t r;
		r.section_byte = b;
		r.kind = k;
		r.run_last = 1'b0;
		return r;
	endfunction

	task automatic reassemble(input in_item_t it);
		out_item_t   res[$];
		logic [7:0]  b;
		logic [3:0]  next_cc;
		logic [11:0] sec_len;
		bit          consume;
		bit          broken;
		b = it.payload_byte;
		consume = 1'b1;
		if (it.packet_first) begin
			if (sec_phase == PH_TAIL && collecting) begin
				res = {res, make_res(8'h00, KIND_DROP)};
				collecting = 1'b0;
			end
			sec_phase = PH_IDLE;
			hdr_cnt = '0;
			next_cc = last_cc + 4'd1;
			broken = cc_known && (next_cc != it.continuity);
			last_cc = it.continuity;
			cc_known = 1'b1;
			consume = 1'b0;
			if (broken) begin
				if (collecting) begin
					res = {res, make_res(8'h00, KIND_DROP)};
					collecting = 1'b0;
				end
			end else if (it.unit_start) begin
				if (b == 8'h00 && !it.packet_last) begin
					if (collecting) begin
						res = {res, make_res(8'h00, KIND_CLOSE)};
						collecting = 1'b0;
					end
					sec_phase = PH_HEAD;
				end else begin
					ptr_left = b;
					sec_phase = PH_TAIL;
				end
			end else if (collecting) begin
				sec_phase = PH_BODY_CONT;
				consume = 1'b1;
			end
		end
		if (consume) begin
			case (sec_phase)
				PH_TAIL: begin
					if (collecting) begin
						res = {res, make_res(b, KIND_DATA)};
					end
					if (ptr_left != 0) begin
						ptr_left = ptr_left - 8'd1;
					end
					if (ptr_left == 0 && !it.packet_last) begin
						if (collecting) begin
							res[res.size() - 1].kind = KIND_FINAL;
							collecting = 1'b0;
						end
						sec_phase = PH_HEAD;
						hdr_cnt = '0;
					end
				end
				PH_HEAD: begin
					if (hdr_cnt == 0 && b == STUFF_BYTE) begin
						sec_phase = PH_IDLE;
					end else if (hdr_cnt < 2) begin
						hdr_hold = {hdr_hold[7:0], b};
						hdr_cnt = hdr_cnt + 2'd1;
					end else begin
						sec_len = {hdr_hold[3:0], b};
						res = {res, make_res(hdr_hold[15:8], KIND_DATA)};
						res = {res, make_res(hdr_hold[7:0], KIND_DATA)};
						res = {res, make_res(b, (sec_len == 0) ? KIND_FINAL : KIND_DATA)};
						hdr_cnt = '0;
						if (sec_len != 0) begin
							collecting = 1'b1;
							body_left = {1'b0, sec_len};
							sec_phase = PH_BODY_START;
						end
					end
				end
				PH_BODY_START, PH_BODY_CONT: begin
					if (body_left != 0) begin
						body_left = body_left - 13'd1;
					end
					if (body_left == 0) begin
						res = {res, make_res(b, KIND_FINAL)};
						collecting = 1'b0;
						sec_phase = (sec_phase == PH_BODY_START) ? PH_HEAD : PH_IDLE;
						hdr_cnt = '0;
					end else begin
						res = {res, make_res(b, KIND_DATA)};
					end
				end
				default: begin
				end
			endcase
		end
		if (it.packet_last) begin
			if (sec_phase == PH_TAIL && collecting) begin
				res = {res, make_res(8'h00, KIND_DROP)};
				collecting = 1'b0;
			end
			sec_phase = PH_IDLE;
			hdr_cnt = '0;
		end
		if (res.size() > 0) begin
			res[res.size() - 1].run_last = 1'b1;
		end
		foreach (res[i]) begin
			expected_results = {expected_results, res[i]};
		end
	endtask

	task automatic check_result(input out_item_t got);
		out_item_t want;
		if (expected_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("unexpected result: byte %h kind %0d last %0b",
					got.section_byte, got.kind, got.run_last);
			end
		end else begin
			want = expected_results.pop_front();
			if (got.section_byte !== want.section_byte || got.kind !== want.kind ||
					got.run_last !== want.run_last) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("result mismatch: expected byte %h kind %0d last %0b,",
						want.section_byte, want.kind, want.run_last);
					$display("  got byte %h kind %0d last %0b",
						got.section_byte, got.kind, got.run_last);
				end
			end
		end
	endtask

	task automatic send_packet(input bit us, input logic [3:0] cc, input byte_q_t bytes,
			input bit mark_last);
		in_item_t it;
		foreach (bytes[i]) begin
			it.payload_byte = bytes[i];
			it.packet_first = (i == 0);
			it.packet_last = (i == bytes.size() - 1) && mark_last;
			it.unit_start = us;
			it.continuity = cc;
			pending_bytes = {pending_bytes, it};
		end
	endtask

	task automatic make_section(ref byte_q_t carry);
		logic [11:0] sec_len;
		logic [3:0]  upper;
		int          body;
		if ($urandom_range(0, 9) < 8) begin
			sec_len = 12'($urandom_range(0, 8));
		end else begin
			sec_len = 12'($urandom);
		end
		upper = 4'($urandom);
		carry = {carry, 8'($urandom_range(0, 254))};
		carry = {carry, {upper, sec_len[11:8]}};
		carry = {carry, sec_len[7:0]};
		body = (sec_len > 40) ? $urandom_range(1, 6) : sec_len;
		repeat (body) begin
			carry = {carry, 8'($urandom)};
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : driver
		int gap;
		if (!arst_n) begin
			item_valid <= 1'b0;
			send_hold <= 0;
		end else if (!item_valid || item_ready) begin
			if (item_valid) begin
				reassemble(item);
				gap = draw_gap(send_quiet);
			end else begin
				gap = send_hold;
			end
			if (gap == 0 && pending_bytes.size() > 0) begin
				item <= pending_bytes.pop_front();
				item_valid <= 1'b1;
				send_hold <= 0;
			end else begin
				item_valid <= 1'b0;
				send_hold <= (gap > 0) ? gap - 1 : 0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : monitor
		int gap;
		if (!arst_n) begin
			result_ready <= 1'b0;
			recv_hold <= 0;
		end else if (result_valid && result_ready) begin
			check_result(result);
			gap = draw_gap(recv_quiet);
			recv_hold <= gap;
			result_ready <= (gap == 0);
		end else if (recv_hold != 0) begin
			recv_hold <= recv_hold - 1;
			result_ready <= (recv_hold == 1);
		end else begin
			result_ready <= 1'b1;
		end
	end

	initial begin : stimulus
		byte_q_t    carry;
		byte_q_t    payload;
		logic [3:0] cc;
		logic [3:0] cc_next;
		logic [7:0] ptr;
		int         plen;
		int         target;
		bit         us;

		// Zero-length section, then stuffing ends the packet.
		send_packet(1'b1, 4'd0, {8'h00, 8'h00, 8'h00, 8'h00, 8'hFF}, 1'b1);
		// A section that spans into the next packet.
		send_packet(1'b1, 4'd1, {8'h00, 8'h02, 8'h30, 8'h03, 8'h01}, 1'b1);
		// A zero pointer closes it; a new one starts.
		send_packet(1'b1, 4'd2, {8'h00, 8'h03, 8'hF0, 8'h02, 8'h77}, 1'b1);
		// The pointer tail finishes it and a header is cut by the packet end.
		send_packet(1'b1, 4'd3, {8'h01, 8'h88, 8'h00}, 1'b1);
		// Longest length, then a continuity break drops it.
		send_packet(1'b1, 4'd4, {8'h00, 8'h05, 8'h0F, 8'hFF}, 1'b1);
		send_packet(1'b0, 4'd6, {8'hAB}, 1'b1);
		// A section that ends exactly on the last payload byte.
		send_packet(1'b1, 4'd7, {8'h00, 8'hFE, 8'h00, 8'h01, 8'h5A}, 1'b1);

		cc_next = 4'd8;
		target = pending_bytes.size() + 340;
		while (pending_bytes.size() < target) begin
			plen = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
			cc = cc_next;
			if ($urandom_range(0, 11) == 0) begin
				cc = cc_next + 4'($urandom_range(1, 15));
			end
			cc_next = cc + 4'd1;
			us = (carry.size() > 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 6) != 0);
			payload.delete();
			if (us) begin
				ptr = 8'(carry.size());
				if ($urandom_range(0, 9) == 0) begin
					ptr = 8'($urandom_range(0, plen));
				end else if ($urandom_range(0, 39) == 0) begin
					ptr = 8'hFF;
				end
				payload = {payload, ptr};
				for (int i = 0; i < ptr && payload.size() < plen; i++) begin
					payload = {payload,
						(carry.size() > 0) ? carry.pop_front() : 8'($urandom)};
				end
				carry.delete();
			end
			while (payload.size() < plen) begin
				if (carry.size() == 0) begin
					if (!us) begin
						payload = {payload, 8'($urandom)};
						continue;
					end
					if ($urandom_range(0, 5) == 0) begin
						while (payload.size() < plen) begin
							payload = {payload, STUFF_BYTE};
						end
						break;
					end
					make_section(carry);
				end
				payload = {payload, carry.pop_front()};
			end
			send_packet(us, cc, payload, $urandom_range(0, 19) != 0);
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_bytes.size() != 0 || item_valid || expected_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (20) @(negedge clk);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("PASS ts_psi_section_reassembler_unit");
		end else begin
			$display("FAIL ts_psi_section_reassembler_unit");
		end
		$finish;
	end

	initial begin : watchdog
		#2000000;
		$display("FAIL ts_psi_section_reassembler_unit");
		$finish;
	end

endmodule
